>>> sv/mte_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Membership table engine package
// Shared constants, codes and types for the membership table engine.
// ----------------------------------------------------------------------------
package mte_pkg;

  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMP_W       = 7;
  localparam int unsigned MAX_EMIT    = 32;

  localparam logic [1:0] ST_ALIVE   = 2'd0;
  localparam logic [1:0] ST_SUSPECT = 2'd1;
  localparam logic [1:0] ST_DEAD    = 2'd2;

  typedef enum logic [2:0] {
    OP_ADD        = 3'd0,
    OP_UPDATE     = 3'd1,
    OP_REMOVE     = 3'd2,
    OP_LOOKUP     = 3'd3,
    OP_LIST_KIND  = 3'd4,
    OP_LIST_ALIVE = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    RC_OK        = 2'd0,
    RC_FULL      = 2'd1,
    RC_NOT_FOUND = 2'd2,
    RC_EMPTY     = 2'd3
  } rc_e;

  typedef struct packed {
    logic [31:0] key;
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [63:0] inc;
    logic [63:0] seen;
    logic [15:0] gport;
    logic [15:0] dport;
    logic [31:0] ipv4;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic rd;
    logic inc_idx;
    logic list_hit;
    logic act;
    logic finish;
    logic shift_wr;
    logic shift_done;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       idx_lt_cnt;
    logic       key_match;
    logic       filter_match;
    logic       limit_reached;
    logic       hit_ready;
    logic       out_free;
  } status_t;

endpackage
`default_nettype wire

>>> sv/mte_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Membership table engine controller
// Sequences the scan, update, shift and result steps of one operation.
// ----------------------------------------------------------------------------
module mte_ctrl
  import mte_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [2:0] operation_i,
  input  wire status_t    sts_i,
  output cmd_t            cmd_o,
  output logic            in_stall_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_CMP, S_ACT, S_FIN, S_SH_RD, S_SH_WR, S_SH_DONE
  } state_e;

  state_e state_q, state_d;
  logic   is_list;

  assign is_list    = (sts_i.op == OP_LIST_KIND) || (sts_i.op == OP_LIST_ALIVE);
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = (operation_i > OP_LIST_ALIVE) ? S_FIN : S_RD;
        end
      end
      S_RD: begin
        if (is_list && sts_i.limit_reached) begin
          state_d = S_FIN;
        end else if (sts_i.idx_lt_cnt) begin
          cmd_o.rd = 1'b1;
          state_d  = S_CMP;
        end else begin
          state_d = S_FIN;
        end
      end
      S_CMP: begin
        if (is_list) begin
          if (!sts_i.filter_match) begin
            cmd_o.inc_idx = 1'b1;
            state_d = S_RD;
          end else if (sts_i.hit_ready) begin
            cmd_o.list_hit = 1'b1;
            cmd_o.inc_idx  = 1'b1;
            state_d = S_RD;
          end
        end else if (sts_i.key_match) begin
          state_d = S_ACT;
        end else begin
          cmd_o.inc_idx = 1'b1;
          state_d = S_RD;
        end
      end
      S_ACT: begin
        if (sts_i.op == OP_REMOVE) begin
          cmd_o.act = 1'b1;
          state_d = S_SH_RD;
        end else if (sts_i.out_free) begin
          cmd_o.act = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_SH_RD: begin
        if (sts_i.idx_lt_cnt) begin
          cmd_o.rd = 1'b1;
          state_d  = S_SH_WR;
        end else begin
          state_d = S_SH_DONE;
        end
      end
      S_SH_WR: begin
        cmd_o.shift_wr = 1'b1;
        state_d = S_SH_RD;
      end
      S_SH_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.shift_done = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

>>> sv/mte_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Membership table engine datapath
// Entry memory, operand registers, entry count and the result register.
// ----------------------------------------------------------------------------
module mte_dp
  import mte_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  output status_t          sts_o,
  input  wire logic        cfg_we_i,
  input  wire logic [5:0]  cfg_wdata_i,
  input  wire logic [2:0]  operation_i,
  input  wire logic [31:0] member_id_i,
  input  wire logic [1:0]  member_kind_i,
  input  wire logic [1:0]  member_status_i,
  input  wire logic [63:0] member_incarnation_i,
  input  wire logic [15:0] gossip_port_in_i,
  input  wire logic [15:0] data_port_in_i,
  input  wire logic [31:0] ipv4_in_i,
  input  wire logic [63:0] now_ms_i,
  input  wire logic [5:0]  list_limit_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       result_code_o,
  output logic [31:0]      out_id_o,
  output logic [1:0]       out_kind_o,
  output logic [1:0]       out_status_o,
  output logic [63:0]      out_incarnation_o,
  output logic [63:0]      out_last_seen_o,
  output logic [15:0]      out_gossip_port_o,
  output logic [15:0]      out_data_port_o,
  output logic [31:0]      out_ipv4_o,
  output logic [5:0]       occupancy_o,
  output logic             last_o
);

  entry_t mem [TABLE_DEPTH];
  entry_t rdata_q;

  logic [5:0]       cap_q;
  logic [CNT_W-1:0] cnt_q, idx_q;
  logic [5:0]       found_q;
  logic             pend_v_q;
  logic [31:0]      pend_id_q;
  logic             ov_q;

  logic [2:0]  op_q;
  logic [31:0] id_q, ipv4_q;
  logic [1:0]  kind_q, st_q;
  logic [63:0] inc_q, now_q;
  logic [15:0] gp_q, dport_q;
  logic [5:0]  lim_q;

  logic [CMP_W-1:0] cap_eff;
  logic             full, newer, rejoin, out_free;
  entry_t           in_entry, wdata;
  logic             we;
  logic [ADDR_W-1:0] waddr;

  logic        push, o_last;
  rc_e         o_code;
  entry_t      o_ent;
  logic [CNT_W-1:0] o_occ;

  assign out_free = !ov_q || !out_stall_i;
  assign cap_eff  = (CMP_W'(cap_q) > CMP_W'(TABLE_DEPTH)) ? CMP_W'(TABLE_DEPTH)
                                                          : CMP_W'(cap_q);
  assign full     = CMP_W'(cnt_q) >= cap_eff;
  assign newer    = inc_q >= rdata_q.inc;
  assign rejoin   = (st_q == ST_ALIVE) && (rdata_q.status == ST_DEAD);

  assign in_entry = '{key: id_q, kind: kind_q, status: st_q, inc: inc_q, seen: now_q,
                      gport: gp_q, dport: dport_q, ipv4: ipv4_q};

  assign sts_o.op            = op_q;
  assign sts_o.idx_lt_cnt    = idx_q < cnt_q;
  assign sts_o.key_match     = rdata_q.key == id_q;
  assign sts_o.filter_match  = (rdata_q.kind == kind_q) &&
                               ((op_q == OP_LIST_KIND) || (rdata_q.status == ST_ALIVE));
  assign sts_o.limit_reached = (found_q >= lim_q) || (found_q >= 6'(MAX_EMIT));
  assign sts_o.hit_ready     = !pend_v_q || out_free;
  assign sts_o.out_free      = out_free;

  always_comb begin
    we    = 1'b0;
    waddr = idx_q[ADDR_W-1:0];
    wdata = in_entry;
    if (cmd_i.act && (op_q == OP_ADD)) begin
      we = rejoin || newer;
      if (rejoin) begin
        wdata.inc = inc_q + 64'd1;
      end
    end else if (cmd_i.act && (op_q == OP_UPDATE)) begin
      we    = newer;
      wdata = rdata_q;
      wdata.status = st_q;
      wdata.inc    = inc_q;
      if ((st_q == ST_ALIVE) || ((st_q == ST_SUSPECT) && (rdata_q.status == ST_ALIVE))) begin
        wdata.seen = now_q;
      end
    end else if (cmd_i.finish && (op_q == OP_ADD) && !full) begin
      we    = 1'b1;
      waddr = cnt_q[ADDR_W-1:0];
    end else if (cmd_i.shift_wr) begin
      we    = 1'b1;
      waddr = idx_q[ADDR_W-1:0] - ADDR_W'(1);
      wdata = rdata_q;
    end
  end

  always_comb begin
    push   = 1'b0;
    o_code = RC_OK;
    o_ent  = '0;
    o_last = 1'b1;
    o_occ  = cnt_q;
    if (cmd_i.list_hit && pend_v_q) begin
      push       = 1'b1;
      o_ent.key  = pend_id_q;
      o_last     = 1'b0;
    end
    if (cmd_i.act && (op_q != OP_REMOVE)) begin
      push = 1'b1;
      if (op_q == OP_LOOKUP) begin
        o_ent = rdata_q;
      end
    end
    if (cmd_i.finish) begin
      push = 1'b1;
      unique case (op_q)
        OP_ADD: begin
          if (full) begin
            o_code = RC_FULL;
          end else begin
            o_occ = cnt_q + CNT_W'(1);
          end
        end
        OP_UPDATE, OP_REMOVE, OP_LOOKUP: o_code = RC_NOT_FOUND;
        OP_LIST_KIND, OP_LIST_ALIVE: begin
          if (pend_v_q) begin
            o_ent.key = pend_id_q;
          end else begin
            o_code = RC_EMPTY;
          end
        end
        default: o_code = RC_OK;
      endcase
    end
    if (cmd_i.shift_done) begin
      push  = 1'b1;
      o_occ = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[idx_q[ADDR_W-1:0]];
    end
    if (cmd_i.capture) begin
      op_q    <= operation_i;
      id_q    <= member_id_i;
      kind_q  <= member_kind_i;
      st_q    <= member_status_i;
      inc_q   <= member_incarnation_i;
      gp_q    <= gossip_port_in_i;
      dport_q <= data_port_in_i;
      ipv4_q  <= ipv4_in_i;
      now_q   <= now_ms_i;
      lim_q   <= list_limit_i;
    end
    if (cmd_i.list_hit) begin
      pend_id_q <= rdata_q.key;
    end
    if (push) begin
      result_code_o     <= o_code;
      out_id_o          <= o_ent.key;
      out_kind_o        <= o_ent.kind;
      out_status_o      <= o_ent.status;
      out_incarnation_o <= o_ent.inc;
      out_last_seen_o   <= o_ent.seen;
      out_gossip_port_o <= o_ent.gport;
      out_data_port_o   <= o_ent.dport;
      out_ipv4_o        <= o_ent.ipv4;
      occupancy_o       <= 6'(o_occ);
      last_o            <= o_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= 6'd32;
      cnt_q    <= '0;
      idx_q    <= '0;
      found_q  <= '0;
      pend_v_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.capture) begin
        idx_q    <= '0;
        found_q  <= '0;
        pend_v_q <= 1'b0;
      end else if (cmd_i.inc_idx || cmd_i.shift_wr || (cmd_i.act && (op_q == OP_REMOVE))) begin
        idx_q <= idx_q + CNT_W'(1);
      end
      if (cmd_i.list_hit) begin
        pend_v_q <= 1'b1;
        found_q  <= found_q + 6'd1;
      end
      if (cmd_i.finish && (op_q == OP_ADD) && !full) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (cmd_i.shift_done) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
      if (push) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = ov_q;

endmodule
`default_nettype wire

>>> sv/membership_table_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Membership table engine
// Insertion-ordered table of cluster members with merge, status update,
// remove, lookup and filtered list operations.
// ----------------------------------------------------------------------------
// The engine takes one operation at a time; the input stays stalled until
// the operation ends, and a stalled result beat holds it longer.
// Reset clears the entry count and sets the capacity register to 32; the
// entry memory is not cleared.
module membership_table_engine
  import mte_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [5:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  operation_i,
  input  wire logic [31:0] member_id_i,
  input  wire logic [1:0]  member_kind_i,
  input  wire logic [1:0]  member_status_i,
  input  wire logic [63:0] member_incarnation_i,
  input  wire logic [15:0] gossip_port_in_i,
  input  wire logic [15:0] data_port_in_i,
  input  wire logic [31:0] ipv4_in_i,
  input  wire logic [63:0] now_ms_i,
  input  wire logic [5:0]  list_limit_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       result_code_o,
  output logic [31:0]      out_id_o,
  output logic [1:0]       out_kind_o,
  output logic [1:0]       out_status_o,
  output logic [63:0]      out_incarnation_o,
  output logic [63:0]      out_last_seen_o,
  output logic [15:0]      out_gossip_port_o,
  output logic [15:0]      out_data_port_o,
  output logic [31:0]      out_ipv4_o,
  output logic [5:0]       occupancy_o,
  output logic             last_o
);

  cmd_t    cmd;
  status_t sts;

  mte_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o)
  );

  mte_dp u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .cfg_we_i             (cfg_we_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .operation_i          (operation_i),
    .member_id_i          (member_id_i),
    .member_kind_i        (member_kind_i),
    .member_status_i      (member_status_i),
    .member_incarnation_i (member_incarnation_i),
    .gossip_port_in_i     (gossip_port_in_i),
    .data_port_in_i       (data_port_in_i),
    .ipv4_in_i            (ipv4_in_i),
    .now_ms_i             (now_ms_i),
    .list_limit_i         (list_limit_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .result_code_o        (result_code_o),
    .out_id_o             (out_id_o),
    .out_kind_o           (out_kind_o),
    .out_status_o         (out_status_o),
    .out_incarnation_o    (out_incarnation_o),
    .out_last_seen_o      (out_last_seen_o),
    .out_gossip_port_o    (out_gossip_port_o),
    .out_data_port_o      (out_data_port_o),
    .out_ipv4_o           (out_ipv4_o),
    .occupancy_o          (occupancy_o),
    .last_o               (last_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Engine accepted a second beat while busy.");

  a_fail_has_no_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_code_o != RC_OK) |-> (out_id_o == 32'd0))
    else $error("Failed result carries an id.");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_code_o == RC_EMPTY) |-> last_o)
    else $error("Empty list result is not the final beat.");

endmodule
`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Membership table engine testbench
// Drives add, status update, remove, lookup and list operations through the
// valid/stall handshake with bursty sending and a stalling receiver, predicts
// every result beat from a behavioural copy of the table, and compares each
// received beat field by field. The capacity register is changed between
// phases while the block is idle, including its extreme values.
// ----------------------------------------------------------------------------
module testbench;
  import mte_pkg::*;

  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam int         WATCHDOG_LIMIT = 5000;
  localparam int         DRAIN_CYCLES = 80;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] id;
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [63:0] inc;
    logic [15:0] gport;
    logic [15:0] dport;
    logic [31:0] ipv4;
    logic [63:0] now;
    logic [5:0]  limit;
  } request_t;

  typedef struct {
    logic [1:0]  code;
    logic [31:0] id;
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [63:0] inc;
    logic [63:0] seen;
    logic [15:0] gport;
    logic [15:0] dport;
    logic [31:0] ipv4;
    logic [5:0]  occ;
    logic        last;
  } reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [5:0]  cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  operation_i = '0;
  logic [31:0] member_id_i = '0;
  logic [1:0]  member_kind_i = '0;
  logic [1:0]  member_status_i = '0;
  logic [63:0] member_incarnation_i = '0;
  logic [15:0] gossip_port_in_i = '0;
  logic [15:0] data_port_in_i = '0;
  logic [31:0] ipv4_in_i = '0;
  logic [63:0] now_ms_i = '0;
  logic [5:0]  list_limit_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  result_code_o;
  logic [31:0] out_id_o;
  logic [1:0]  out_kind_o;
  logic [1:0]  out_status_o;
  logic [63:0] out_incarnation_o;
  logic [63:0] out_last_seen_o;
  logic [15:0] out_gossip_port_o;
  logic [15:0] out_data_port_o;
  logic [31:0] out_ipv4_o;
  logic [5:0]  occupancy_o;
  logic        last_o;

  membership_table_engine u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .operation_i, .member_id_i, .member_kind_i, .member_status_i,
    .member_incarnation_i, .gossip_port_in_i, .data_port_in_i, .ipv4_in_i,
    .now_ms_i, .list_limit_i, .out_valid_o, .out_stall_i, .result_code_o,
    .out_id_o, .out_kind_o, .out_status_o, .out_incarnation_o, .out_last_seen_o,
    .out_gossip_port_o, .out_data_port_o, .out_ipv4_o, .occupancy_o, .last_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  request_t    pending_requests[$];
  reply_t      expected_replies[$];
  request_t    driven_request;
  entry_t      member_table[TABLE_DEPTH];
  int          member_count = 0;
  logic [5:0]  capacity_reg = 6'd32;
  int          error_count = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          cycle_count = 0;
  logic [31:0] id_pool[8] = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h2, 32'h3,
                              32'h8000_0000, 32'h5A5A_5A5A, 32'hA5A5_A5A5};

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic reply_t blank_reply(input logic [1:0] code, input logic [31:0] id);
    reply_t r;
    r = '{default: '0};
    r.code = code;
    r.id = id;
    r.occ = 6'(member_count);
    return r;
  endfunction

  task automatic predict_member_op(input request_t rq);
    int     slot;
    int     cap;
    int     found;
    reply_t r;
    reply_t burst[$];
    logic [1:0] prior_status;
    entry_t e;
    slot = -1;
    for (int i = member_count - 1; i >= 0; i--)
      if (member_table[i].key == rq.id) slot = i;
    cap = (capacity_reg > TABLE_DEPTH) ? TABLE_DEPTH : capacity_reg;
    e = '{key: rq.id, kind: rq.kind, status: rq.status, inc: rq.inc, seen: rq.now,
          gport: rq.gport, dport: rq.dport, ipv4: rq.ipv4};
    r = blank_reply(RC_OK, '0);
    case (rq.op)
      OP_ADD: begin
        if (slot >= 0) begin
          if (rq.status == ST_ALIVE && member_table[slot].status == ST_DEAD) begin
            e.inc = rq.inc + 64'd1;
            member_table[slot] = e;
          end else if (rq.inc >= member_table[slot].inc) begin
            member_table[slot] = e;
          end
        end else if (member_count >= cap) begin
          r.code = RC_FULL;
        end else begin
          member_table[member_count] = e;
          member_count++;
        end
        r.occ = 6'(member_count);
      end
      OP_UPDATE: begin
        if (slot < 0) begin
          r.code = RC_NOT_FOUND;
        end else if (rq.inc >= member_table[slot].inc) begin
          prior_status = member_table[slot].status;
          member_table[slot].status = rq.status;
          member_table[slot].inc = rq.inc;
          if (rq.status == ST_ALIVE || (rq.status == ST_SUSPECT && prior_status == ST_ALIVE))
            member_table[slot].seen = rq.now;
        end
      end
      OP_REMOVE: begin
        if (slot < 0) begin
          r.code = RC_NOT_FOUND;
        end else begin
          for (int i = slot; i + 1 < member_count; i++) member_table[i] = member_table[i + 1];
          member_count--;
          r.occ = 6'(member_count);
        end
      end
      OP_LOOKUP: begin
        if (slot < 0) begin
          r.code = RC_NOT_FOUND;
        end else begin
          r.id = member_table[slot].key;
          r.kind = member_table[slot].kind;
          r.status = member_table[slot].status;
          r.inc = member_table[slot].inc;
          r.seen = member_table[slot].seen;
          r.gport = member_table[slot].gport;
          r.dport = member_table[slot].dport;
          r.ipv4 = member_table[slot].ipv4;
        end
      end
      OP_LIST_KIND, OP_LIST_ALIVE: begin
        found = 0;
        for (int i = 0; i < member_count; i++) begin
          if (found >= rq.limit || found >= MAX_EMIT) break;
          if (member_table[i].kind == rq.kind &&
              (rq.op == OP_LIST_KIND || member_table[i].status == ST_ALIVE)) begin
            burst.push_back(blank_reply(RC_OK, member_table[i].key));
            found++;
          end
        end
        if (found == 0) burst.push_back(blank_reply(RC_EMPTY, '0));
        burst[burst.size() - 1].last = 1'b1;
        foreach (burst[i]) expected_replies.push_back(burst[i]);
        return;
      end
      default: ;
    endcase
    r.last = 1'b1;
    expected_replies.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) predict_member_op(driven_request);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          driven_request = pending_requests.pop_front();
          operation_i <= driven_request.op;
          member_id_i <= driven_request.id;
          member_kind_i <= driven_request.kind;
          member_status_i <= driven_request.status;
          member_incarnation_i <= driven_request.inc;
          gossip_port_in_i <= driven_request.gport;
          data_port_in_i <= driven_request.dport;
          ipv4_in_i <= driven_request.ipv4;
          now_ms_i <= driven_request.now;
          list_limit_i <= driven_request.limit;
          in_valid_i <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      cycle_count <= 0;
    end else begin
      cycle_count <= cycle_count + 1;
      case ((cycle_count / 64) % 3)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        default: out_stall_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("unexpected beat id", 64'(out_id_o), '0);
      end else begin
        want = expected_replies.pop_front();
        if (result_code_o !== want.code)
          report_mismatch("result_code", 64'(result_code_o), 64'(want.code));
        if (out_id_o !== want.id) report_mismatch("out_id", 64'(out_id_o), 64'(want.id));
        if (out_kind_o !== want.kind)
          report_mismatch("out_kind", 64'(out_kind_o), 64'(want.kind));
        if (out_status_o !== want.status)
          report_mismatch("out_status", 64'(out_status_o), 64'(want.status));
        if (out_incarnation_o !== want.inc)
          report_mismatch("out_incarnation", out_incarnation_o, want.inc);
        if (out_last_seen_o !== want.seen)
          report_mismatch("out_last_seen", out_last_seen_o, want.seen);
        if (out_gossip_port_o !== want.gport)
          report_mismatch("out_gossip_port", 64'(out_gossip_port_o), 64'(want.gport));
        if (out_data_port_o !== want.dport)
          report_mismatch("out_data_port", 64'(out_data_port_o), 64'(want.dport));
        if (out_ipv4_o !== want.ipv4)
          report_mismatch("out_ipv4", 64'(out_ipv4_o), 64'(want.ipv4));
        if (occupancy_o !== want.occ)
          report_mismatch("occupancy", 64'(occupancy_o), 64'(want.occ));
        if (last_o !== want.last) report_mismatch("last", 64'(last_o), 64'(want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic request_t make_request(input logic [2:0] op, input logic [31:0] id,
                                            input logic [1:0] kind, input logic [1:0] status,
                                            input logic [63:0] inc, input logic [5:0] limit);
    request_t rq;
    rq.op = op;
    rq.id = id;
    rq.kind = kind;
    rq.status = status;
    rq.inc = inc;
    rq.gport = 16'($urandom);
    rq.dport = 16'($urandom);
    rq.ipv4 = $urandom;
    rq.now = {$urandom, $urandom};
    rq.limit = limit;
    return rq;
  endfunction

  function automatic request_t random_request();
    logic [2:0]  op;
    logic [31:0] id;
    logic [63:0] inc;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) op = OP_ADD;
    else if (pick < 55) op = OP_UPDATE;
    else if (pick < 65) op = OP_REMOVE;
    else if (pick < 80) op = OP_LOOKUP;
    else if (pick < 88) op = OP_LIST_KIND;
    else if (pick < 96) op = OP_LIST_ALIVE;
    else op = ($urandom_range(0, 1) != 0) ? OP_SPARE_6 : OP_SPARE_7;
    id = ($urandom_range(0, 9) == 0) ? $urandom : id_pool[$urandom_range(0, 7)];
    case ($urandom_range(0, 5))
      0: inc = {$urandom, $urandom};
      1: inc = '1;
      default: inc = 64'($urandom_range(0, 12));
    endcase
    return make_request(op, id, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), inc,
                        ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(1, 6)));
  endfunction

  task automatic wait_drained();
    while (pending_requests.size() > 0 || in_valid_i || expected_replies.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [5:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    capacity_reg = value;
  endtask

  initial begin
    logic [5:0] capacities[6] = '{6'd1, 6'd0, 6'd63, 6'd5, 6'd40, 6'd32};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    pending_requests.push_back(make_request(OP_LIST_KIND, 32'h1, 2'd0, ST_ALIVE, '0, 6'd32));
    pending_requests.push_back(make_request(OP_LOOKUP, 32'h1, 2'd0, ST_ALIVE, '0, 6'd1));
    pending_requests.push_back(make_request(OP_UPDATE, 32'h1, 2'd0, ST_ALIVE, '0, 6'd1));
    pending_requests.push_back(make_request(OP_REMOVE, 32'h1, 2'd0, ST_ALIVE, '0, 6'd1));
    pending_requests.push_back(make_request(OP_ADD, 32'h0, 2'd0, ST_ALIVE, 64'd5, 6'd1));
    pending_requests.push_back(make_request(OP_ADD, 32'h0, 2'd1, ST_SUSPECT, 64'd3, 6'd1));
    pending_requests.push_back(make_request(OP_ADD, 32'h0, 2'd1, ST_DEAD, 64'd7, 6'd1));
    pending_requests.push_back(make_request(OP_ADD, 32'h0, 2'd2, ST_ALIVE, 64'd0, 6'd1));
    pending_requests.push_back(make_request(OP_ADD, 32'hFFFF_FFFF, 2'd3, ST_DEAD, '1, 6'd1));
    pending_requests.push_back(make_request(OP_ADD, 32'hFFFF_FFFF, 2'd3, ST_ALIVE, '1, 6'd1));
    pending_requests.push_back(make_request(OP_LOOKUP, 32'hFFFF_FFFF, 2'd0, ST_ALIVE, '0, 6'd1));
    pending_requests.push_back(make_request(OP_ADD, 32'h2, 2'd3, ST_ALIVE, 64'd4, 6'd1));
    pending_requests.push_back(make_request(OP_UPDATE, 32'h2, 2'd0, ST_SUSPECT, 64'd4, 6'd1));
    pending_requests.push_back(make_request(OP_UPDATE, 32'h2, 2'd0, 2'd3, 64'd9, 6'd1));
    pending_requests.push_back(make_request(OP_UPDATE, 32'h2, 2'd0, ST_SUSPECT, 64'd9, 6'd1));
    pending_requests.push_back(make_request(OP_UPDATE, 32'h2, 2'd0, ST_ALIVE, 64'd2, 6'd1));
    pending_requests.push_back(make_request(OP_UPDATE, 32'h2, 2'd0, ST_ALIVE, 64'd10, 6'd1));
    pending_requests.push_back(make_request(OP_LOOKUP, 32'h2, 2'd0, ST_ALIVE, '0, 6'd1));
    pending_requests.push_back(make_request(OP_LIST_KIND, '0, 2'd3, ST_ALIVE, '0, 6'd63));
    pending_requests.push_back(make_request(OP_LIST_ALIVE, '0, 2'd3, ST_ALIVE, '0, 6'd1));
    pending_requests.push_back(make_request(OP_LIST_KIND, '0, 2'd3, ST_ALIVE, '0, 6'd0));
    pending_requests.push_back(make_request(OP_REMOVE, 32'h0, 2'd0, ST_ALIVE, '0, 6'd1));
    pending_requests.push_back(make_request(OP_LOOKUP, 32'h0, 2'd0, ST_ALIVE, '0, 6'd1));
    pending_requests.push_back(make_request(OP_SPARE_6, 32'h2, 2'd0, ST_ALIVE, '0, 6'd1));
    pending_requests.push_back(make_request(OP_SPARE_7, 32'h2, 2'd0, ST_ALIVE, '0, 6'd1));
    for (int i = 0; i < 40; i++) pending_requests.push_back(random_request());
    wait_drained();

    foreach (capacities[c]) begin
      write_capacity(capacities[c]);
      for (int i = 0; i < 45; i++) pending_requests.push_back(random_request());
      wait_drained();
    end

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
